>>> src/wpfre_pkg.sv
// ----------------------------------------------------------------------------
// wpfre_pkg
// Shared types and constants of the probe frame record extractor.
// ----------------------------------------------------------------------------
package wpfre_pkg;

    localparam int ADDR_W      = 48;
    localparam int HASH_W      = 64;
    localparam int WORD_BYTES  = 8;
    localparam int LANE_W      = 3;
    localparam int POS_W       = 5;

    localparam logic [POS_W-1:0]  HEADER_END = 5'd22;
    localparam logic [POS_W-1:0]  DST_FIRST  = 5'd4;
    localparam logic [POS_W-1:0]  SRC_FIRST  = 5'd10;
    localparam logic [POS_W-1:0]  BSS_FIRST  = 5'd16;
    localparam logic [HASH_W-1:0] HASH_SEED  = 64'd17;
    localparam logic [3:0]        SUBTYPE_RESET = 4'd4;
    localparam logic [LANE_W-1:0] LANE_LAST  = 3'd7;

    // one frame byte handed to the frame state blocks
    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] data;
    } wpfre_step_t;

    // header fields as they stand after the current byte
    typedef struct packed {
        logic [7:0]        ctrl;
        logic [ADDR_W-1:0] src;
        logic [ADDR_W-1:0] dst;
        logic [ADDR_W-1:0] bss;
    } wpfre_hdr_t;

endpackage

>>> src/wpfre_hdr_capture.sv
// ----------------------------------------------------------------------------
// wpfre_hdr_capture
// Tracks the header position and collects frame control and the addresses.
// ----------------------------------------------------------------------------
module wpfre_hdr_capture
    import wpfre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wpfre_step_t step_in,
    output wpfre_hdr_t  hdr_next
);

    logic [POS_W-1:0] header_pos_reg;
    logic [POS_W-1:0] header_pos_next;
    wpfre_hdr_t       hdr_reg;

    always_comb
    begin
        hdr_next = hdr_reg;
        if (header_pos_reg == '0)
        begin
            hdr_next.ctrl = step_in.data;
        end
        for (int k = 0; k < 6; k++)
        begin
            // first address byte lands in the most significant position
            if (header_pos_reg == DST_FIRST + POS_W'(k))
            begin
                hdr_next.dst[ADDR_W-1-8*k -: 8] = step_in.data;
            end
            if (header_pos_reg == SRC_FIRST + POS_W'(k))
            begin
                hdr_next.src[ADDR_W-1-8*k -: 8] = step_in.data;
            end
            if (header_pos_reg == BSS_FIRST + POS_W'(k))
            begin
                hdr_next.bss[ADDR_W-1-8*k -: 8] = step_in.data;
            end
        end
        header_pos_next = header_pos_reg;
        if (header_pos_reg < HEADER_END)
        begin
            header_pos_next = header_pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_pos_reg <= '0;
            hdr_reg        <= '0;
        end
        else if (step_in.step)
        begin
            if (step_in.last)
            begin
                header_pos_reg <= '0;
                hdr_reg        <= '0;
            end
            else
            begin
                header_pos_reg <= header_pos_next;
                hdr_reg        <= hdr_next;
            end
        end
    end

endmodule

>>> src/wpfre_hash.sv
// ----------------------------------------------------------------------------
// wpfre_hash
// Polynomial hash over complete little-endian 64-bit words of the frame.
// ----------------------------------------------------------------------------
module wpfre_hash
    import wpfre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  wpfre_step_t       step_in,
    output logic [HASH_W-1:0] hash_next
);

    logic [HASH_W-1:0]              hash_reg;
    logic [8*(WORD_BYTES-1)-1:0]    word_reg;
    logic [8*(WORD_BYTES-1)-1:0]    word_next;
    logic [LANE_W-1:0]              lane_reg;
    logic [LANE_W-1:0]              lane_next;
    logic [HASH_W-1:0]              word_full;
    logic [HASH_W-1:0]              hash_x31;

    assign word_full = {step_in.data, word_reg};
    // h*31 as h*32 - h
    assign hash_x31  = {hash_reg[HASH_W-6:0], 5'b0} - hash_reg;

    always_comb
    begin
        hash_next = hash_reg;
        word_next = word_reg;
        lane_next = lane_reg + LANE_W'(1);
        if (lane_reg == LANE_LAST)
        begin
            hash_next = hash_x31 + word_full;
            word_next = '0;
        end
        else
        begin
            for (int k = 0; k < WORD_BYTES-1; k++)
            begin
                if (lane_reg == LANE_W'(k))
                begin
                    word_next[8*k +: 8] = step_in.data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= HASH_SEED;
            word_reg <= '0;
            lane_reg <= '0;
        end
        else if (step_in.step)
        begin
            if (step_in.last)
            begin
                hash_reg <= HASH_SEED;
                word_reg <= '0;
                lane_reg <= '0;
            end
            else
            begin
                hash_reg <= hash_next;
                word_reg <= word_next;
                lane_reg <= lane_next;
            end
        end
    end

endmodule

>>> src/wifi_probe_frame_record_extractor.sv
// ----------------------------------------------------------------------------
// wifi_probe_frame_record_extractor
// Parses 802.11 frames byte by byte and reports one record per matching frame.
// ----------------------------------------------------------------------------
// The last byte passes the input register and then the result register, which
// puts the record on m_tvalid. Throughput: one byte per cycle; the input and
// result registers each move one transaction a cycle unless the output stalls.
// Reset: rst_n clears all frame state (hash back to 17), empties both
// registers and sets the subtype match to 4 (probe request).
// ----------------------------------------------------------------------------
module wifi_probe_frame_record_extractor
    import wpfre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // frame_byte[7:0], signal_strength[15:8], rx_time[47:16]
    input  logic [47:0]  s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // sender_address[47:0], receiver_address[95:48], network_id[143:96],
    // strength_out[151:144], time_out[183:152], frame_hash[247:184]
    output logic [247:0] m_tdata
);

    logic         stage_valid_reg;
    logic         stage_last_reg;
    logic [47:0]  stage_data_reg;
    logic [3:0]   subtype_reg;
    logic         m_tvalid_reg;
    logic [247:0] m_tdata_reg;
    logic         advance;
    logic         record_hit;

    wpfre_step_t       step_bus;
    wpfre_hdr_t        hdr_next;
    logic [HASH_W-1:0] hash_next;

    assign advance  = !stage_valid_reg || !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign step_bus.step = stage_valid_reg && advance;
    assign step_bus.last = stage_last_reg;
    assign step_bus.data = stage_data_reg[7:0];

    assign record_hit = step_bus.step && stage_last_reg && (hdr_next.ctrl[7:4] == subtype_reg);

    wpfre_hdr_capture u_hdr
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_in  (step_bus),
        .hdr_next (hdr_next)
    );

    wpfre_hash u_hash
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_in   (step_bus),
        .hash_next (hash_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            subtype_reg <= SUBTYPE_RESET;
        end
        else if (cfg_wr_en)
        begin
            subtype_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_tvalid)
        begin
            stage_last_reg <= s_tlast;
            stage_data_reg <= s_tdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (record_hit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (record_hit)
        begin
            m_tdata_reg <= {hash_next, stage_data_reg[47:16], stage_data_reg[15:8],
                            hdr_next.bss, hdr_next.dst, hdr_next.src};
        end
    end

`ifndef NO_ASSERTIONS
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled while result register is empty");

    a_record_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(stage_valid_reg && stage_last_reg))
        else $error("record raised without a last byte in the input register");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg && m_tvalid_reg && !m_tready |=> stage_valid_reg)
        else $error("pending byte dropped while output stalled");
`endif

endmodule
